// ===== rtl/core/bfd_pkg.sv =====
// bfd_pkg: shared constants, types and helper functions for the box filter downscaler
// used by bfd_front, bfd_queue, bfd_back and box_filter_downscale_unit
// no dependencies
package bfd_pkg;

   localparam int FACTOR     = 2;
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int CFG_W      = 12;
   localparam int PIX_W      = 8;
   localparam int NCH        = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

   localparam int SUM_DEPTH = MAX_WIDTH / FACTOR;
   localparam int ADDR_W    = $clog2(SUM_DEPTH);
   localparam int WDIM_W    = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W    = $clog2(MAX_HEIGHT + 1);
   localparam int CX_W      = (FACTOR > 1) ? $clog2(FACTOR) : 1;

   // block mean by reciprocal multiply, exact for every sum that can occur
   localparam int AREA    = FACTOR * FACTOR;
   localparam int SUM_W   = $clog2(AREA * 255 + 1);
   localparam int DIV_LOG = $clog2(AREA);
   localparam int DIV_K   = SUM_W + DIV_LOG;
   localparam int RECIP_W = DIV_K + 1;
   localparam int RECIP   = ((1 << DIV_K) + AREA - 1) / AREA;
   localparam int PROD_W  = SUM_W + RECIP_W;

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);
   localparam int ODEPTH  = 4;
   localparam int OPTR_W  = $clog2(ODEPTH);
   localparam int OCNT_W  = $clog2(ODEPTH + 1);

   typedef enum logic [0:0] {
      REG_SOURCE_WIDTH  = 1'b0,
      REG_SOURCE_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      pixel_type         px;
      logic [ADDR_W-1:0] addr;
      logic              first;
      logic              last;
      logic              row_end;
      logic              frame_end;
   } work_type;

   typedef struct packed {
      logic              frame_end;
      logic              row_end;
      pixel_type         px;
   } result_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              empty;
      logic              full;
   } queue_status_type;

   function automatic logic [WDIM_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
      int unsigned t;
      t = 32'(v);
      if (t == 0) begin
         t = 1;
      end else if (t > MAX_WIDTH) begin
         t = MAX_WIDTH;
      end
      return WDIM_W'(t);
   endfunction

   function automatic logic [HDIM_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
      int unsigned t;
      t = 32'(v);
      if (t == 0) begin
         t = 1;
      end else if (t > MAX_HEIGHT) begin
         t = MAX_HEIGHT;
      end
      return HDIM_W'(t);
   endfunction

   function automatic logic [PIX_W-1:0] block_mean(input logic [SUM_W-1:0] s);
      logic [PROD_W-1:0] p;
      p = PROD_W'(s) * PROD_W'(RECIP);
      return PIX_W'(p >> DIV_K);
   endfunction

endpackage

// ===== rtl/core/bfd_front.sv =====
// bfd_front: accepts source pixels, tracks raster position and block membership
// pushes pixels inside whole blocks into the work queue; depends on bfd_pkg
module bfd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       restart,
   input  logic [bfd_pkg::CFG_W-1:0]  source_width,
   input  logic [bfd_pkg::CFG_W-1:0]  source_height,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  bfd_pkg::pixel_type         req_pixel,
   input  logic                       queue_full,
   output logic                       push,
   output bfd_pkg::work_type          push_item
);
   import bfd_pkg::*;

   logic [WDIM_W-1:0] col_ff, col_in, bstart_c_ff, bstart_c_in;
   logic [HDIM_W-1:0] row_ff, row_in, bstart_r_ff, bstart_r_in;
   logic [CX_W-1:0]   cx_ff, cx_in, ry_ff, ry_in;
   logic [ADDR_W-1:0] bc_ff, bc_in;

   logic [WDIM_W-1:0] w_eff;
   logic [HDIM_W-1:0] h_eff;
   logic              accept;
   logic              col_wrap, row_wrap, cx_wrap, ry_wrap;
   logic              col_in_block, row_in_block, col_last_block, row_last_block;

   assign w_eff  = clamp_width(source_width);
   assign h_eff  = clamp_height(source_height);
   assign req_tready = !queue_full;
   assign accept = req_tvalid && req_tready;

   assign col_wrap = ((WDIM_W+1)'(col_ff) + (WDIM_W+1)'(1)) >= (WDIM_W+1)'(w_eff);
   assign row_wrap = ((HDIM_W+1)'(row_ff) + (HDIM_W+1)'(1)) >= (HDIM_W+1)'(h_eff);
   assign cx_wrap  = (cx_ff == CX_W'(FACTOR - 1));
   assign ry_wrap  = (ry_ff == CX_W'(FACTOR - 1));

   // a block counts only if it lies wholly inside the image
   assign col_in_block   = ((WDIM_W+1)'(bstart_c_ff) + (WDIM_W+1)'(FACTOR))
                           <= (WDIM_W+1)'(w_eff);
   assign col_last_block = ((WDIM_W+1)'(bstart_c_ff) + (WDIM_W+1)'(2 * FACTOR))
                           > (WDIM_W+1)'(w_eff);
   assign row_in_block   = ((HDIM_W+1)'(bstart_r_ff) + (HDIM_W+1)'(FACTOR))
                           <= (HDIM_W+1)'(h_eff);
   assign row_last_block = ((HDIM_W+1)'(bstart_r_ff) + (HDIM_W+1)'(2 * FACTOR))
                           > (HDIM_W+1)'(h_eff);

   always_comb begin
      push_item.px        = req_pixel;
      push_item.addr      = bc_ff;
      push_item.first     = (cx_ff == '0) && (ry_ff == '0);
      push_item.last      = cx_wrap && ry_wrap;
      push_item.row_end   = col_last_block;
      push_item.frame_end = col_last_block && row_last_block;
      push = accept && col_in_block && row_in_block && !restart;
   end

   always_comb begin
      col_in      = col_ff;
      cx_in       = cx_ff;
      bc_in       = bc_ff;
      bstart_c_in = bstart_c_ff;
      row_in      = row_ff;
      ry_in       = ry_ff;
      bstart_r_in = bstart_r_ff;
      if (restart) begin
         col_in      = '0;
         cx_in       = '0;
         bc_in       = '0;
         bstart_c_in = '0;
         row_in      = '0;
         ry_in       = '0;
         bstart_r_in = '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_in      = '0;
            cx_in       = '0;
            bc_in       = '0;
            bstart_c_in = '0;
            if (row_wrap) begin
               row_in      = '0;
               ry_in       = '0;
               bstart_r_in = '0;
            end else begin
               row_in = row_ff + HDIM_W'(1);
               if (ry_wrap) begin
                  ry_in       = '0;
                  bstart_r_in = bstart_r_ff + HDIM_W'(FACTOR);
               end else begin
                  ry_in = ry_ff + CX_W'(1);
               end
            end
         end else begin
            col_in = col_ff + WDIM_W'(1);
            if (cx_wrap) begin
               cx_in       = '0;
               bc_in       = bc_ff + ADDR_W'(1);
               bstart_c_in = bstart_c_ff + WDIM_W'(FACTOR);
            end else begin
               cx_in = cx_ff + CX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         cx_ff       <= '0;
         bc_ff       <= '0;
         bstart_c_ff <= '0;
         row_ff      <= '0;
         ry_ff       <= '0;
         bstart_r_ff <= '0;
      end else begin
         col_ff      <= col_in;
         cx_ff       <= cx_in;
         bc_ff       <= bc_in;
         bstart_c_ff <= bstart_c_in;
         row_ff      <= row_in;
         ry_ff       <= ry_in;
         bstart_r_ff <= bstart_r_in;
      end
   end

endmodule

// ===== rtl/core/bfd_queue.sv =====
// bfd_queue: short work queue between the front and the back
// depends on bfd_pkg for the work word type and depth
module bfd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bfd_pkg::work_type         push_item,
   input  logic                      pop,
   output bfd_pkg::work_type         head,
   output bfd_pkg::queue_status_type status
);
   import bfd_pkg::*;

   work_type          slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_W'(QDEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/bfd_back.sv =====
// bfd_back: line buffer of block sums with read-modify-write, block mean and result buffer
// depends on bfd_pkg for sizes, types and the mean function
module bfd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  bfd_pkg::queue_status_type q_status,
   input  bfd_pkg::work_type         head,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output bfd_pkg::result_type       rsp_result
);
   import bfd_pkg::*;

   logic [NCH-1:0][SUM_W-1:0] sum_mem [SUM_DEPTH];
   logic [NCH-1:0][SUM_W-1:0] rd_ff;

   logic                      s1_valid_ff;
   work_type                  s1_item_ff;
   logic                      fwd_valid_ff;
   logic [ADDR_W-1:0]         fwd_addr_ff;
   logic [NCH-1:0][SUM_W-1:0] fwd_data_ff;

   logic [NCH-1:0][SUM_W-1:0] base;
   logic [NCH-1:0][SUM_W-1:0] sum_in;
   logic [NCH-1:0][PIX_W-1:0] pix;
   result_type                res_in;

   result_type                out_ff [ODEPTH];
   logic [OPTR_W-1:0]         o_wr_ff, o_wr_in, o_rd_ff, o_rd_in;
   logic [OCNT_W-1:0]         o_cnt_ff, o_cnt_in;
   logic [OCNT_W:0]           occupancy;
   logic                      o_push, o_pop;

   // only pop when the result buffer has room for the item in flight and this one
   assign occupancy = (OCNT_W+1)'(o_cnt_ff) + (OCNT_W+1)'(s1_valid_ff);
   assign pop       = !q_status.empty && (occupancy < (OCNT_W+1)'(ODEPTH));

   assign pix[0] = s1_item_ff.px.red;
   assign pix[1] = s1_item_ff.px.green;
   assign pix[2] = s1_item_ff.px.blue;

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         if (s1_item_ff.first) begin
            base[c] = '0;
         end else if (fwd_valid_ff && (fwd_addr_ff == s1_item_ff.addr)) begin
            // previous write to the same entry missed the registered read
            base[c] = fwd_data_ff[c];
         end else begin
            base[c] = rd_ff[c];
         end
         sum_in[c] = base[c] + SUM_W'(pix[c]);
      end
   end

   always_comb begin
      res_in.px.red    = block_mean(sum_in[0]);
      res_in.px.green  = block_mean(sum_in[1]);
      res_in.px.blue   = block_mean(sum_in[2]);
      res_in.row_end   = s1_item_ff.row_end;
      res_in.frame_end = s1_item_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= sum_mem[head.addr];
      end
      if (s1_valid_ff) begin
         sum_mem[s1_item_ff.addr] <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_item_ff <= head;
      end
      fwd_addr_ff <= s1_item_ff.addr;
      fwd_data_ff <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= pop;
         fwd_valid_ff <= s1_valid_ff;
      end
   end

   assign o_push     = s1_valid_ff && s1_item_ff.last;
   assign rsp_tvalid = (o_cnt_ff != '0);
   assign o_pop      = rsp_tvalid && rsp_tready;
   assign rsp_result = out_ff[o_rd_ff];

   always_comb begin
      o_wr_in  = o_push ? o_wr_ff + OPTR_W'(1) : o_wr_ff;
      o_rd_in  = o_pop  ? o_rd_ff + OPTR_W'(1) : o_rd_ff;
      o_cnt_in = o_cnt_ff + OCNT_W'(o_push) - OCNT_W'(o_pop);
   end

   always_ff @(posedge clock) begin
      if (o_push) begin
         out_ff[o_wr_ff] <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_wr_ff  <= '0;
         o_rd_ff  <= '0;
         o_cnt_ff <= '0;
      end else begin
         o_wr_ff  <= o_wr_in;
         o_rd_ff  <= o_rd_in;
         o_cnt_ff <= o_cnt_in;
      end
   end

endmodule

// ===== rtl/core/box_filter_downscale_unit.sv =====
// box_filter_downscale_unit: top level of the FACTOR x FACTOR box filter downscaler
// instantiates bfd_front, bfd_queue and bfd_back; depends on bfd_pkg
//
// usage:
//  req_* carries source RGB pixels in raster order, one word per pixel.
//  rsp_* carries one downscaled pixel per whole block, in raster order of the
//  output image; tlast marks the last pixel of an output row, tuser the last
//  pixel of the frame. columns and rows past the last whole block are dropped.
//  csr_* is an APB-style port: source_width at 0x0, source_height at 0x4.
//  a write restarts the frame at its first pixel; write only while idle.
// timing:
//  one pixel per clock is taken while the work queue is not full. a result
//  becomes valid once the last pixel of its block has passed the work queue,
//  the registered line-buffer read and the accumulate/mean stage.
// reset:
//  synchronous, clears position counters and all queues; the size registers
//  return to 640 x 480. no line-buffer clearing is needed.
// stall:
//  when rsp_tready is low results collect in a four-word buffer, then the
//  four-word work queue fills and req_tready drops.
module box_filter_downscale_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,   // in_red, in_green, in_blue
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // out_red, out_green, out_blue
   output logic                           rsp_tlast,   // row_end
   output logic [0:0]                     rsp_tuser,   // frame_end
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bfd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bfd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bfd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bfd_pkg::*;

   logic [CFG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic             csr_write;
   reg_index_type    csr_index;

   pixel_type        req_pixel;
   logic             q_push, q_pop;
   work_type         q_push_item, q_head;
   queue_status_type q_status;
   result_type       rsp_result;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_SOURCE_WIDTH:  width_in  = csr_pwdata[CFG_W-1:0];
            REG_SOURCE_HEIGHT: height_in = csr_pwdata[CFG_W-1:0];
            default:           width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SOURCE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_SOURCE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign req_pixel.red   = req_tdata[7:0];
   assign req_pixel.green = req_tdata[15:8];
   assign req_pixel.blue  = req_tdata[23:16];

   bfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .restart       (csr_write),
      .source_width  (width_ff),
      .source_height (height_ff),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_pixel     (req_pixel),
      .queue_full    (q_status.full),
      .push          (q_push),
      .push_item     (q_push_item)
   );

   bfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   bfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {rsp_result.px.blue, rsp_result.px.green, rsp_result.px.red};
   assign rsp_tlast = rsp_result.row_end;
   assign rsp_tuser = rsp_result.frame_end;

   // the end of a frame is always also the end of a row
   a_frame_implies_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame end without row end");

   a_reset_no_result: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("work queue popped while empty");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.full |=> (q_status.count <= QCNT_W'(QDEPTH)))
      else $error("work queue overflow");

endmodule
